[rtl/core/gbfr_pkg.sv]
// ----------------------------------------------------------------------------
// gbfr_pkg
// Shared types, constants and the message decoder of the binary frame receiver.
// ----------------------------------------------------------------------------
package gbfr_pkg;

   localparam logic [10:0] MaxPayload   = 11'd1024;
   localparam logic [10:0] CsrLenReset  = 11'd1024;
   localparam logic [7:0]  SyncFirst    = 8'hB5;
   localparam logic [7:0]  SyncSecond   = 8'h62;

   localparam logic [3:0] PhHunt1   = 4'd0;
   localparam logic [3:0] PhHunt2   = 4'd1;
   localparam logic [3:0] PhClass   = 4'd2;
   localparam logic [3:0] PhId      = 4'd3;
   localparam logic [3:0] PhLenLo   = 4'd4;
   localparam logic [3:0] PhLenHi   = 4'd5;
   localparam logic [3:0] PhPayload = 4'd6;
   localparam logic [3:0] PhCkA     = 4'd7;
   localparam logic [3:0] PhCkB     = 4'd8;

   localparam logic KindPayload = 1'b0;
   localparam logic KindReport  = 1'b1;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusBadSum  = 2'd1;
   localparam logic [1:0] StatusUnknown = 2'd2;
   localparam logic [1:0] StatusTooLong = 2'd3;

   localparam logic [3:0] MsgUnknown = 4'd0;
   localparam logic [3:0] MsgNavPvt  = 4'd1;
   localparam logic [3:0] MsgNavDop  = 4'd2;
   localparam logic [3:0] MsgNavSat  = 4'd3;
   localparam logic [3:0] MsgMonGnss = 4'd4;
   localparam logic [3:0] MsgMonVer  = 4'd5;
   localparam logic [3:0] MsgAckAck  = 4'd6;
   localparam logic [3:0] MsgAckNak  = 4'd7;
   localparam logic [3:0] MsgUniqId  = 4'd8;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_data;
      logic [9:0]  byte_index;
      logic [7:0]  frame_class;
      logic [7:0]  frame_id;
      logic [3:0]  message_kind;
      logic [1:0]  status;
      logic [15:0] frame_count;
      logic [15:0] good_count;
      logic [15:0] bad_count;
   } rsp_item_type;

   function automatic logic [3:0] decode_kind(input logic [7:0] cls, input logic [7:0] id);
      logic [3:0] mk;
      mk = MsgUnknown;
      case (cls)
         8'h01: begin
            if (id == 8'h07) mk = MsgNavPvt;
            else if (id == 8'h04) mk = MsgNavDop;
            else if (id == 8'h35) mk = MsgNavSat;
         end
         8'h0A: begin
            if (id == 8'h28) mk = MsgMonGnss;
            else if (id == 8'h04) mk = MsgMonVer;
         end
         8'h05: begin
            if (id == 8'h01) mk = MsgAckAck;
            else if (id == 8'h00) mk = MsgAckNak;
         end
         8'h27: begin
            if (id == 8'h03) mk = MsgUniqId;
         end
         default: mk = MsgUnknown;
      endcase
      return mk;
   endfunction

endpackage

[rtl/core/gnss_binary_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// gnss_binary_frame_receiver_unit
// Receiver for binary GNSS frames with sync hunt and 8-bit Fletcher checksum.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle on the request channel while it is not
// stalled, with no gaps needed between bytes. Each byte is handled in the cycle
// it is accepted by the frame state machine, and any response (a payload byte
// with its index, or a frame-end report carrying class, id, message type, status
// and the running frame counters) is driven onto the response channel from a register.
// A two-deep response buffer lets requests keep flowing while one response
// waits; the request channel stalls only when both entries are held.
// The payload limit is the smaller of the written register and 1024 bytes;
// write it only while no frame is in progress.
module gnss_binary_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // payload_data, byte_index, frame_class, frame_id,
                                    // message_kind, status, frame_count, good_count,
                                    // bad_count
   output logic        rsp_tuser,   // kind
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data  // max_payload_len
);
   import gbfr_pkg::*;

   logic [10:0]  max_len_ff;
   logic         step_en;
   logic         res_valid;
   rsp_item_type res_item;
   rsp_item_type out_item;
   logic         can_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= CsrLenReset;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   assign req_tready = can_push;
   assign step_en    = req_tvalid && can_push;

   gbfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .rx_byte   (req_tdata),
      .max_len   (max_len_ff),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   gbfr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_item (res_item),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tuser = out_item.kind;
   assign rsp_tdata = {out_item.bad_count, out_item.good_count, out_item.frame_count,
                       out_item.status, out_item.message_kind, out_item.frame_id,
                       out_item.frame_class, out_item.byte_index, out_item.payload_data};

   a_full_implies_valid: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("Request side stalled with no response held.");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KindPayload) |-> (rsp_tdata[39:34] == 6'd0))
      else $error("Payload response carries a message type or status.");

   a_ok_known: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KindReport && rsp_tdata[39:38] == StatusOk)
      |-> (rsp_tdata[37:34] != MsgUnknown))
      else $error("Good frame report with unknown message type.");

   a_report_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KindReport) |-> (rsp_tdata[17:0] == 18'd0))
      else $error("Frame report carries payload data or index.");

endmodule

[rtl/core/gbfr_parser.sv]
// ----------------------------------------------------------------------------
// gbfr_parser
// Byte-wide frame state machine with checksum, length check and counters.
// ----------------------------------------------------------------------------
module gbfr_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [7:0]            rx_byte,
   input  logic [10:0]           max_len,
   output logic                  res_valid,
   output gbfr_pkg::rsp_item_type res_item
);
   import gbfr_pkg::*;

   logic [3:0]  phase_ff,   phase_in;
   logic [7:0]  class_ff,   class_in;
   logic [7:0]  id_ff,      id_in;
   logic [15:0] len_ff,     len_in;
   logic [10:0] pos_ff,     pos_in;
   logic [7:0]  sum_a_ff,   sum_a_in;
   logic [7:0]  sum_b_ff,   sum_b_in;
   logic [7:0]  rcv_a_ff,   rcv_a_in;
   logic [15:0] total_ff,   total_in;
   logic [15:0] good_ff,    good_in;
   logic [15:0] bad_ff,     bad_in;

   logic [10:0] limit;
   logic [7:0]  add_a;
   logic [7:0]  add_b;
   logic [15:0] len_full;
   logic [10:0] pos_next;
   logic [3:0]  mk;

   assign limit    = (max_len > MaxPayload) ? MaxPayload : max_len;
   assign add_a    = sum_a_ff + rx_byte;
   assign add_b    = sum_b_ff + add_a;
   assign len_full = {rx_byte, len_ff[7:0]};
   assign pos_next = pos_ff + 11'd1;
   assign mk       = decode_kind(class_ff, id_ff);

   always_comb begin
      phase_in = phase_ff;
      class_in = class_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      rcv_a_in = rcv_a_ff;
      total_in = total_ff;
      good_in  = good_ff;
      bad_in   = bad_ff;
      res_valid = 1'b0;
      res_item.kind         = KindReport;
      res_item.payload_data = 8'd0;
      res_item.byte_index   = 10'd0;
      res_item.message_kind = MsgUnknown;
      res_item.status       = StatusOk;
      if (step_en) begin
         case (phase_ff)
            PhHunt2: begin
               if (rx_byte == SyncSecond) begin
                  phase_in = PhClass;
                  sum_a_in = 8'd0;
                  sum_b_in = 8'd0;
               end else if (rx_byte != SyncFirst) begin
                  phase_in = PhHunt1;
               end
            end
            PhClass: begin
               class_in = rx_byte;
               sum_a_in = add_a;
               sum_b_in = add_b;
               phase_in = PhId;
            end
            PhId: begin
               id_in    = rx_byte;
               sum_a_in = add_a;
               sum_b_in = add_b;
               phase_in = PhLenLo;
            end
            PhLenLo: begin
               len_in   = {8'd0, rx_byte};
               sum_a_in = add_a;
               sum_b_in = add_b;
               phase_in = PhLenHi;
            end
            PhLenHi: begin
               len_in   = len_full;
               sum_a_in = add_a;
               sum_b_in = add_b;
               pos_in   = 11'd0;
               if (len_full > {5'd0, limit}) begin
                  total_in        = total_ff + 16'd1;
                  phase_in        = PhHunt1;
                  res_valid       = 1'b1;
                  res_item.status = StatusTooLong;
               end else if (len_full == 16'd0) begin
                  phase_in = PhCkA;
               end else begin
                  phase_in = PhPayload;
               end
            end
            PhPayload: begin
               sum_a_in              = add_a;
               sum_b_in              = add_b;
               res_valid             = 1'b1;
               res_item.kind         = KindPayload;
               res_item.payload_data = rx_byte;
               res_item.byte_index   = pos_ff[9:0];
               pos_in                = pos_next;
               if ({5'd0, pos_next} >= len_ff) phase_in = PhCkA;
            end
            PhCkA: begin
               rcv_a_in = rx_byte;
               phase_in = PhCkB;
            end
            PhCkB: begin
               phase_in  = PhHunt1;
               total_in  = total_ff + 16'd1;
               res_valid = 1'b1;
               if (rcv_a_ff != sum_a_ff || rx_byte != sum_b_ff) begin
                  bad_in          = bad_ff + 16'd1;
                  res_item.status = StatusBadSum;
               end else begin
                  good_in               = good_ff + 16'd1;
                  res_item.message_kind = mk;
                  res_item.status       = (mk == MsgUnknown) ? StatusUnknown : StatusOk;
               end
            end
            default: begin
               phase_in = (rx_byte == SyncFirst) ? PhHunt2 : PhHunt1;
            end
         endcase
      end
      res_item.frame_class = class_in;
      res_item.frame_id    = id_in;
      res_item.frame_count = total_in;
      res_item.good_count  = good_in;
      res_item.bad_count   = bad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhHunt1;
         class_ff <= 8'd0;
         id_ff    <= 8'd0;
         len_ff   <= 16'd0;
         pos_ff   <= 11'd0;
         sum_a_ff <= 8'd0;
         sum_b_ff <= 8'd0;
         rcv_a_ff <= 8'd0;
         total_ff <= 16'd0;
         good_ff  <= 16'd0;
         bad_ff   <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         rcv_a_ff <= rcv_a_in;
         total_ff <= total_in;
         good_ff  <= good_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

[rtl/core/gbfr_skid.sv]
// ----------------------------------------------------------------------------
// gbfr_skid
// Result register with a skid stage, so the input side never waits on the
// combinational ready of the output side.
// ----------------------------------------------------------------------------
module gbfr_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gbfr_pkg::rsp_item_type push_item,
   output logic                   can_push,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gbfr_pkg::rsp_item_type out_item
);
   import gbfr_pkg::*;

   logic         out_valid_ff,  out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff,   out_item_in;
   rsp_item_type skid_item_ff,  skid_item_in;
   logic         drain;

   assign drain     = !out_valid_ff || out_ready;
   assign can_push  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_item_in  = push_item;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_item_in  = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule
